[rtl/core/oaht_pkg.sv]
// Shared types and constants for the open-address hash table unit.
// Used by the controller, the datapath and the top level; no dependencies.
package oaht_pkg;

	// Table geometry; SLOTS must be a power of two so that key mod SLOTS is a bit slice.
	localparam int SLOTS   = 256;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;
	localparam int MARK_W  = 2;
	localparam int ENTRY_W = MARK_W + KEY_W + VAL_W;

	// Request kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// Slot marks
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	// Result codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_CLEARED   = 3'd6;

	// Controller to datapath
	typedef struct packed {
		logic load;       // capture request, read start slot
		logic advance;    // step to next probe slot, read it
		logic rec_tomb;   // remember current slot as first tombstone
		logic wr_insert;  // write new live entry (at tombstone if one was seen)
		logic wr_update;  // overwrite value of matching live entry
		logic wr_remove;  // turn matching live entry into a tombstone
		logic clear_all;  // drop every slot
		logic result;     // a result is produced this cycle
		logic take_found; // result carries the slot's value
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [MARK_W-1:0] mark;  // effective mark of the slot under test
		logic              key_hit;
		logic              last_probe;
		logic              have_tomb;
		logic              saturated;
		logic              table_empty;
	} dp_stat_t;

endpackage

[rtl/core/open_address_hash_table_unit.sv]
// Top level of the open-address hash table unit (64-bit keys and values).
// Instantiates oaht_ctrl and oaht_dp; types and constants from oaht_pkg.
//
// Usage:
//   Request channel: drive kind, key and entry_value and raise start; the
//   request is taken at a rising edge where start is high and busy is low.
//   kind selects insert/update, lookup, remove or clear all.
//   Result channel: done is high for exactly one cycle with status and
//   found_value valid in that cycle. The receiver cannot stall; every
//   result must be taken in the cycle it is shown.
// Response and throughput:
//   Clear, a saturated insert and a lookup/remove on an empty table answer
//   in the cycle after the request, and busy never rises.
//   Other requests walk the probe sequence, whose step grows as the square
//   of the probe count, one slot per cycle, limited by the single read port
//   of the slot RAM; a request decides at probe k (k from 1 to SLOTS). busy
//   drops in the same cycle done rises, so the next request can be taken then.
// Reset:
//   arst_n clears all slot valid bits and both occupancy counts, so the table
//   is empty at once; no clearing pass. Clear all does the same.
//   Slot keys and values in the RAM are not initialized.
module open_address_hash_table_unit import oaht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       kind,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] entry_value,
	output logic             done,
	output logic [2:0]       status,
	output logic [VAL_W-1:0] found_value
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing: accept request, walk probes, issue writes, register result
	oaht_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.status(status)
	);

	// Storage and probe arithmetic: slot RAM, valid bits, counters, value register
	oaht_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key),
		.entry_value(entry_value),
		.cmd        (cmd),
		.stat       (stat),
		.found_value(found_value)
	);

endmodule

[rtl/core/oaht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/oaht_dp.sv]
// Datapath of the hash table unit: slot RAM, slot valid bits, probe walk,
// occupancy counters and found-value register. Depends on oaht_pkg and oaht_ram.
module oaht_dp import oaht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] entry_value,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	output logic [VAL_W-1:0] found_value
);

	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   sq_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   tomb_q;
	logic               have_tomb_q;
	logic [SLOTS-1:0]   valid_q;
	logic               vld_s1;
	logic [CNT_W-1:0]   live_q;
	logic [CNT_W-1:0]   tcnt_q;
	logic [VAL_W-1:0]   found_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0] rd_entry;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_entry;
	logic [MARK_W-1:0]  rd_mark;
	logic [KEY_W-1:0]   rd_key;
	logic [VAL_W-1:0]   rd_val;
	logic [IDX_W-1:0]   next_idx;
	logic [CNT_W:0]     occ_sum;

	assign rd_mark = rd_entry[ENTRY_W-1 -: MARK_W];
	assign rd_key  = rd_entry[KEY_W+VAL_W-1 -: KEY_W];
	assign rd_val  = rd_entry[VAL_W-1:0];

	// sq_q holds cnt_q squared mod SLOTS
	assign next_idx = idx_q + sq_q;
	assign rd_en    = cmd.load | cmd.advance;
	assign rd_addr  = cmd.load ? key[IDX_W-1:0] : next_idx;

	assign wr_en    = cmd.wr_insert | cmd.wr_update | cmd.wr_remove;
	assign wr_addr  = (cmd.wr_insert && have_tomb_q) ? tomb_q : idx_q;
	assign wr_entry = cmd.wr_remove ? {MARK_TOMB, rd_key, rd_val} : {MARK_LIVE, key_q, val_q};

	oaht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	assign occ_sum = {1'b0, live_q} + {1'b0, tcnt_q};

	assign stat.mark        = vld_s1 ? rd_mark : MARK_EMPTY;
	assign stat.key_hit     = (rd_key == key_q);
	assign stat.last_probe  = (cnt_q == IDX_W'(SLOTS - 1));
	assign stat.have_tomb   = have_tomb_q;
	assign stat.saturated   = (occ_sum >= (CNT_W+1)'(SLOTS));
	assign stat.table_empty = (live_q == '0);

	assign found_value = found_q;

	// Payload and probe position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
			val_q <= entry_value;
			idx_q <= key[IDX_W-1:0];
			sq_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.advance) begin
			idx_q <= next_idx;
			sq_q  <= sq_q + {cnt_q[IDX_W-2:0], 1'b1};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.rec_tomb) begin
			tomb_q <= idx_q;
		end
		if (cmd.result) begin
			found_q <= cmd.take_found ? rd_val : '0;
		end
	end

	// Slot valid bits, counters and tombstone flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			vld_s1      <= 1'b0;
			live_q      <= '0;
			tcnt_q      <= '0;
			have_tomb_q <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
			if (cmd.load) begin
				have_tomb_q <= 1'b0;
			end else if (cmd.rec_tomb) begin
				have_tomb_q <= 1'b1;
			end
			if (cmd.clear_all) begin
				valid_q <= '0;
				live_q  <= '0;
				tcnt_q  <= '0;
			end else begin
				if (wr_en) begin
					valid_q[wr_addr] <= 1'b1;
				end
				if (cmd.wr_insert) begin
					live_q <= live_q + 1'b1;
					if (have_tomb_q && tcnt_q != '0) begin
						tcnt_q <= tcnt_q - 1'b1;
					end
				end
				if (cmd.wr_remove) begin
					live_q <= live_q - 1'b1;
					tcnt_q <= tcnt_q + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/oaht_ctrl.sv]
// Controller of the hash table unit: accepts requests, steers the probe walk
// and registers busy, result strobe and status. Depends on oaht_pkg.
module oaht_ctrl import oaht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done,
	output logic [2:0] status
);

	typedef enum logic {
		S_IDLE,
		S_PROBE
	} state_t;

	state_t     state_q;
	state_t     state_nx;
	logic [1:0] op_q;
	logic       busy_q;
	logic       done_q;
	logic [2:0] status_q;
	logic [2:0] res_status;

	assign busy   = busy_q;
	assign done   = done_q;
	assign status = status_q;

	always_comb begin
		cmd        = '0;
		res_status = ST_NOT_FOUND;
		state_nx   = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_CLEAR: begin
							cmd.clear_all = 1'b1;
							cmd.result    = 1'b1;
							res_status    = ST_CLEARED;
						end
						KIND_INSERT: begin
							if (stat.saturated) begin
								cmd.result = 1'b1;
								res_status = ST_FULL;
							end else begin
								cmd.load = 1'b1;
								state_nx = S_PROBE;
							end
						end
						default: begin
							if (stat.table_empty) begin
								cmd.result = 1'b1;
								res_status = ST_NOT_FOUND;
							end else begin
								cmd.load = 1'b1;
								state_nx = S_PROBE;
							end
						end
					endcase
				end
			end
			S_PROBE: begin
				if (op_q == KIND_INSERT) begin
					if (stat.mark == MARK_EMPTY) begin
						cmd.wr_insert = 1'b1;
						cmd.result    = 1'b1;
						res_status    = ST_INSERTED;
					end else if (stat.mark == MARK_LIVE && stat.key_hit) begin
						cmd.wr_update = 1'b1;
						cmd.result    = 1'b1;
						res_status    = ST_UPDATED;
					end else begin
						cmd.rec_tomb = (stat.mark == MARK_TOMB) && !stat.have_tomb;
						if (stat.last_probe) begin
							cmd.result = 1'b1;
							res_status = ST_FULL;
						end else begin
							cmd.advance = 1'b1;
						end
					end
				end else begin
					if (stat.mark == MARK_EMPTY) begin
						cmd.result = 1'b1;
						res_status = ST_NOT_FOUND;
					end else if (stat.mark == MARK_LIVE && stat.key_hit) begin
						cmd.result = 1'b1;
						if (op_q == KIND_REMOVE) begin
							cmd.wr_remove = 1'b1;
							res_status    = ST_REMOVED;
						end else begin
							cmd.take_found = 1'b1;
							res_status     = ST_FOUND;
						end
					end else if (stat.last_probe) begin
						cmd.result = 1'b1;
						res_status = ST_NOT_FOUND;
					end else begin
						cmd.advance = 1'b1;
					end
				end
				if (cmd.result) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= KIND_INSERT;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_INSERTED;
		end else begin
			state_q <= state_nx;
			busy_q  <= (state_nx == S_PROBE);
			done_q  <= cmd.result;
			if (cmd.load) begin
				op_q <= kind;
			end
			if (cmd.result) begin
				status_q <= res_status;
			end
		end
	end

endmodule

[verif/tb_open_address_hash_table_unit.sv]
// Self-checking testbench for open_address_hash_table_unit: directed and random
// insert, lookup, remove and clear requests, checked against a behavioral mirror.
// Depends on oaht_pkg and the unit's RTL only.
module tb_open_address_hash_table_unit import oaht_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 12;
	localparam int ITEM_TARGET  = 775;       // directed head plus about 750 random requests
	localparam int CYCLE_LIMIT  = 1_000_000; // well above the slowest legal run
	localparam int POOL_SIZE    = 40;
	localparam int MAX_GAP      = 6;

	// Expected reply for one accepted request.
	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] value;
	} reply_t;

	// Behavioral copy of the slot array; every accepted request updates it and
	// queues the reply the unit owes for it.
	class hash_table_mirror;
		logic [KEY_W-1:0]  slot_key  [SLOTS];
		logic [VAL_W-1:0]  slot_data [SLOTS];
		logic [MARK_W-1:0] slot_mark [SLOTS];
		int unsigned       live_cnt;
		int unsigned       tomb_cnt;
		reply_t            expected_replies [$];
		int unsigned       mismatches;

		function new();
			foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
			live_cnt   = 0;
			tomb_cnt   = 0;
			mismatches = 0;
		endfunction

		// Slot index holding k as a live entry, or SLOTS when absent.
		function int locate(logic [KEY_W-1:0] k);
			int pos;
			pos = int'(k[IDX_W-1:0]);
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_mark[pos] == MARK_EMPTY)
					return SLOTS;
				if (slot_mark[pos] == MARK_LIVE && slot_key[pos] == k)
					return pos;
				pos = (pos + (i * i) % SLOTS) % SLOTS;
			end
			return SLOTS;
		endfunction

		function logic [2:0] insert_entry(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
			int pos;
			int tomb_pos;
			bit have_tomb;
			if (live_cnt + tomb_cnt >= SLOTS)
				return ST_FULL;
			pos       = int'(k[IDX_W-1:0]);
			tomb_pos  = 0;
			have_tomb = 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_mark[pos] == MARK_EMPTY) begin
					if (have_tomb) begin
						pos = tomb_pos;
						if (tomb_cnt > 0)
							tomb_cnt--;
					end
					slot_key[pos]  = k;
					slot_data[pos] = v;
					slot_mark[pos] = MARK_LIVE;
					live_cnt++;
					return ST_INSERTED;
				end
				if (slot_mark[pos] == MARK_LIVE && slot_key[pos] == k) begin
					slot_data[pos] = v;
					return ST_UPDATED;
				end
				if (slot_mark[pos] == MARK_TOMB && !have_tomb) begin
					have_tomb = 1'b1;
					tomb_pos  = pos;
				end
				pos = (pos + (i * i) % SLOTS) % SLOTS;
			end
			return ST_FULL;
		endfunction

		function void take_request(logic [1:0] k, logic [KEY_W-1:0] ky, logic [VAL_W-1:0] v);
			reply_t r;
			int     pos;
			r.status = ST_NOT_FOUND;
			r.value  = '0;
			case (k)
				KIND_INSERT: begin
					r.status = insert_entry(ky, v);
				end
				KIND_LOOKUP: begin
					pos = (live_cnt != 0) ? locate(ky) : SLOTS;
					if (pos < SLOTS) begin
						r.status = ST_FOUND;
						r.value  = slot_data[pos];
					end
				end
				KIND_REMOVE: begin
					pos = (live_cnt != 0) ? locate(ky) : SLOTS;
					if (pos < SLOTS) begin
						slot_mark[pos] = MARK_TOMB;
						live_cnt--;
						tomb_cnt++;
						r.status = ST_REMOVED;
					end
				end
				default: begin
					foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
					live_cnt = 0;
					tomb_cnt = 0;
					r.status = ST_CLEARED;
				end
			endcase
			expected_replies.push_back(r);
		endfunction

		function void check_reply(logic [2:0] st, logic [VAL_W-1:0] v);
			reply_t want;
			bit     stray;
			stray = (expected_replies.size() == 0);
			want  = '0;
			if (!stray)
				want = expected_replies.pop_front();
			if (stray || st !== want.status || v !== want.value) begin
				mismatches++;
				if (mismatches <= 10) begin
					if (stray)
						$display("%0t: reply with nothing pending: status %0d value %h",
							$time, st, v);
					else
						$display("%0t: status exp %0d got %0d, value exp %h got %h",
							$time, want.status, st, want.value, v);
				end
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	// Clock, reset and all unit inputs start at known values.
	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic [1:0]       kind        = KIND_INSERT;
	logic [KEY_W-1:0] key         = '0;
	logic [VAL_W-1:0] entry_value = '0;
	logic             busy;
	logic             done;
	logic [2:0]       status;
	logic [VAL_W-1:0] found_value;

	hash_table_mirror mirror;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               sent        = 0;
	int               cycle_count = 0;

	open_address_hash_table_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.key         (key),
		.entry_value (entry_value),
		.done        (done),
		.status      (status),
		.found_value (found_value)
	);

	always #6 clk = ~clk;

	// Watch both channels at every edge. All reads here see the values from
	// before the edge, so the order against the driver does not matter. A
	// request taken at the same edge as a reply is younger than that reply,
	// so noting it first leaves the queue order intact.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (start === 1'b1 && busy === 1'b0)
				mirror.take_request(kind, key, entry_value);
			if (done === 1'b1)
				mirror.check_reply(status, found_value);
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sender idle rate: light in the first third, heavy in the second,
	// back-to-back requests in the last third.
	function automatic int idle_pct();
		if (sent < ITEM_TARGET / 3)
			return 25;
		if (sent < 2 * ITEM_TARGET / 3)
			return 52;
		return 0;
	endfunction

	// Present one request and hold it until the unit takes it. An optional gap
	// comes first, with start low and junk on the fields, so gaps land at any
	// point of the previous request's probe walk. Returns in the time step of
	// the accepting edge with start still high.
	task automatic issue(input logic [1:0] k, input logic [KEY_W-1:0] ky,
		input logic [VAL_W-1:0] v);
		if ($urandom_range(99) < idle_pct()) begin
			start       <= 1'b0;
			kind        <= 2'($urandom);
			key         <= {$urandom, $urandom};
			entry_value <= {$urandom, $urandom};
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
		start       <= 1'b1;
		kind        <= k;
		key         <= ky;
		entry_value <= v;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sent++;
	endtask

	// Pool of keys crowded onto four home slots, so probe chains collide and
	// overlap. The all-zero and all-ones keys stay in every pool.
	function automatic void refresh_pool();
		logic [IDX_W-1:0] homes [4];
		foreach (homes[i]) homes[i] = IDX_W'($urandom);
		foreach (key_pool[i]) begin
			key_pool[i]            = {$urandom, $urandom};
			key_pool[i][IDX_W-1:0] = homes[i % 4];
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
	endfunction

	// Insert n keys with distinct home slots in random order. On an empty
	// table each lands at its home, so n == SLOTS saturates the table and a
	// smaller n leaves a few holes that some probe chains never reach. Half
	// of the pool takes keys from the fill so later requests hit them.
	task automatic fill_table(input int n);
		int               order [SLOTS];
		int               j;
		int               t;
		logic [KEY_W-1:0] k;
		foreach (order[i]) order[i] = i;
		for (int i = SLOTS - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < n; i++) begin
			k            = {$urandom, $urandom};
			k[IDX_W-1:0] = order[i][IDX_W-1:0];
			if (i < POOL_SIZE / 2)
				key_pool[POOL_SIZE / 2 + i] = k;
			issue(KIND_INSERT, k, {$urandom, $urandom});
		end
	endtask

	// One random request, mostly on pool keys; a few on stray keys, and a
	// rare clear that also reshuffles the pool.
	task automatic mixed_request();
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		int               pick;
		k    = key_pool[$urandom_range(POOL_SIZE - 1)];
		v    = {$urandom, $urandom};
		pick = $urandom_range(99);
		if ($urandom_range(15) == 0)
			v = $urandom_range(1) ? '1 : '0;
		if (pick < 40)
			issue(KIND_INSERT, k, v);
		else if (pick < 68)
			issue(KIND_LOOKUP, k, v);
		else if (pick < 92)
			issue(KIND_REMOVE, k, v);
		else if (pick < 97)
			issue(pick[0] ? KIND_LOOKUP : KIND_REMOVE, {$urandom, $urandom}, v);
		else begin
			issue(KIND_CLEAR, k, v);
			refresh_pool();
		end
	endtask

	initial begin
		int episode;
		mirror = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: lookup and remove miss without probing.
		issue(KIND_LOOKUP, 64'h0, 64'h0);
		issue(KIND_REMOVE, '1, '1);
		// Extremes of key and value, then update in place.
		issue(KIND_INSERT, 64'h0, '1);
		issue(KIND_INSERT, 64'h0, 64'h0);
		issue(KIND_LOOKUP, 64'h0, '1);
		issue(KIND_INSERT, '1, 64'h8000_0000_0000_0001);
		issue(KIND_LOOKUP, '1, 64'h0);
		// Collide on home slot 0 so the probe walk runs past live slots.
		issue(KIND_INSERT, 64'h100, 64'h1);
		issue(KIND_INSERT, 64'h200, 64'h0123_4567_89ab_cdef);
		issue(KIND_LOOKUP, 64'h200, 64'h0);
		// Tombstone in the chain: searches pass it, insert reuses it.
		issue(KIND_REMOVE, 64'h100, 64'h0);
		issue(KIND_LOOKUP, 64'h100, 64'h0);
		issue(KIND_LOOKUP, 64'h200, 64'h0);
		issue(KIND_INSERT, 64'h300, 64'hfedc_ba98_7654_3210);
		issue(KIND_REMOVE, 64'h300, 64'h0);
		issue(KIND_REMOVE, 64'h300, 64'h0);
		// Update behind a tombstone must not move the entry.
		issue(KIND_INSERT, 64'h200, 64'haaaa_aaaa_aaaa_aaaa);
		issue(KIND_LOOKUP, 64'h200, 64'h0);
		// Key missing while the table holds entries.
		issue(KIND_LOOKUP, 64'h5a5a_5a5a_5a5a_5a00, 64'h0);
		issue(KIND_CLEAR, 64'h0, 64'h0);
		issue(KIND_LOOKUP, 64'h200, 64'h0);
		issue(KIND_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		issue(KIND_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		issue(KIND_LOOKUP, 64'h5555_5555_5555_5555, 64'h0);
		issue(KIND_CLEAR, '1, '1);

		// Random episodes: some start by filling the table (the second one
		// fills it completely), all run mixed traffic and end with a clear.
		// Hold the request count near the target: skip a fill that would
		// overshoot it and stop mixed traffic once it is reached.
		refresh_pool();
		episode = 0;
		while (sent < ITEM_TARGET) begin
			if (episode == 1)
				fill_table(SLOTS);
			else if ($urandom_range(3) == 0 && sent + SLOTS < ITEM_TARGET)
				fill_table($urandom_range(SLOTS * 3 / 4, SLOTS - 1));
			repeat ($urandom_range(40, 90)) begin
				if (sent < ITEM_TARGET)
					mixed_request();
			end
			issue(KIND_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
			refresh_pool();
			episode++;
		end
		start <= 1'b0;

		// Drain, then watch a full probe walk longer for stray replies.
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (SLOTS + 2) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
rtl/core/oaht_pkg.sv
rtl/core/oaht_ram.sv
rtl/core/oaht_dp.sv
rtl/core/oaht_ctrl.sv
rtl/core/open_address_hash_table_unit.sv
verif/tb_open_address_hash_table_unit.sv
